>>> hw/rtl/rcq_pkg.sv
// ============================================================================
// Rate-to-count quantizer package
// Shared register map, configuration and control types, and fixed constants.
// ============================================================================
package rcq_pkg;

    // Configuration port address width: five 32-bit registers at 4*i.
    localparam int unsigned CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_GAIN_X,
        REG_GAIN_Y,
        REG_MAX_COUNTS,
        REG_MIN_DT,
        REG_MAX_DT
    } t_reg_idx;

    localparam logic [14:0] MAX_COUNTS_RST = 15'd32767;
    localparam logic [15:0] MIN_DT_RST     = 16'd100;
    localparam logic [15:0] MAX_DT_RST     = 16'd50000;

    // Divisor of the rate scaling: full-scale rate times one million microseconds.
    localparam logic [35:0] RATE_DEN  = 36'd32768000000;
    // The unsigned product |rate| * gain * step fits in 48 bits.
    localparam int unsigned MAG_W     = 48;
    // The divisor is 2^21 * 15625, so a shift leaves a division by 15625.
    localparam int unsigned SCALE_SH  = 21;
    localparam logic [13:0] DIV_K     = 14'd15625;
    // The quotient is formed 16 bits at a time. Each partial dividend is below
    // 2^30, where multiplying by RECIP and shifting right by RECIP_SH is exact.
    localparam int unsigned DIG_W     = 16;
    localparam logic [30:0] RECIP     = 31'd1125899907;
    localparam int unsigned RECIP_SH  = 44;
    // Quotient bits above the fractional part.
    localparam int unsigned Q_HEAD    = 14;

    typedef struct packed {
        logic [15:0] gain_x;
        logic [15:0] gain_y;
        logic [14:0] max_counts;
        logic [15:0] min_dt;
        logic [15:0] max_dt;
    } t_rcq_cfg;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic div_est;
        logic div_fix;
        logic sum;
        logic rnd;
        logic finish;
    } t_rcq_cmd;

    typedef struct packed {
        logic bypass;
    } t_rcq_stat;

endpackage

>>> hw/rtl/rate_to_count_quantizer.sv
// ============================================================================
// Rate-to-count quantizer
// Turns normalized X/Y rates into integer count steps with residual feedback.
// ============================================================================
// An item goes through window check, multiply, ND = ceil((FRAC_BITS+27)/16) quotient
// digits, sum, round and finish; passthrough and out-of-window items skip to finish.
// A new item is accepted only once the last has finished. The divider forms each
// 16-bit quotient digit by an estimate and a correction step, on both axes in parallel.
// A result held by the receiver keeps the next item waiting in finish until it is taken.
// Reset (synchronous, active low) clears both residuals and restores register defaults.
module rate_to_count_quantizer
    import rcq_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = 16,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic signed [15:0]           i_rate_x,
    input  logic signed [15:0]           i_rate_y,
    input  logic [15:0]                  i_step_us,
    input  logic                         i_keep_source_x,
    input  logic                         i_keep_source_y,
    input  logic signed [15:0]           i_source_dx,
    input  logic signed [15:0]           i_source_dy,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COUNT_BITS-1:0] o_step_x,
    output logic signed [COUNT_BITS-1:0] o_step_y,
    output logic                         o_ok,
    output logic                         o_clipped,
    output logic                         o_transparent
);

    t_rcq_cfg  cfg;
    t_rcq_cmd  cmd;
    t_rcq_stat stat;
    logic      gain_wr;

    rcq_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_gain_wr (gain_wr)
    );

    rcq_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rcq_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .i_gain_wr       (gain_wr),
        .i_mode          (i_mode),
        .i_rate_x        (i_rate_x),
        .i_rate_y        (i_rate_y),
        .i_step_us       (i_step_us),
        .i_keep_source_x (i_keep_source_x),
        .i_keep_source_y (i_keep_source_y),
        .i_source_dx     (i_source_dx),
        .i_source_dy     (i_source_dy),
        .o_stat          (stat),
        .o_step_x        (o_step_x),
        .o_step_y        (o_step_y),
        .o_ok            (o_ok),
        .o_clipped       (o_clipped),
        .o_transparent   (o_transparent)
    );

endmodule

>>> hw/rtl/rcq_regs.sv
// ============================================================================
// Rate-to-count quantizer configuration registers
// APB-style register file holding gains, count limit and time-step window.
// ============================================================================
module rcq_regs
    import rcq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_rcq_cfg              o_cfg,
    output logic                  o_gain_wr
);

    t_rcq_cfg r_cfg;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_x     <= '0;
            r_cfg.gain_y     <= '0;
            r_cfg.max_counts <= MAX_COUNTS_RST;
            r_cfg.min_dt     <= MIN_DT_RST;
            r_cfg.max_dt     <= MAX_DT_RST;
        end else if (wr_en) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_GAIN_X:     r_cfg.gain_x     <= pwdata[15:0];
                REG_GAIN_Y:     r_cfg.gain_y     <= pwdata[15:0];
                REG_MAX_COUNTS: r_cfg.max_counts <= pwdata[14:0];
                REG_MIN_DT:     r_cfg.min_dt     <= pwdata[15:0];
                REG_MAX_DT:     r_cfg.max_dt     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_gain_wr = 1'b0;
        if (wr_en) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_GAIN_X, REG_GAIN_Y: o_gain_wr = 1'b1;
                default:                o_gain_wr = 1'b0;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_GAIN_X:     prdata = {16'b0, r_cfg.gain_x};
            REG_GAIN_Y:     prdata = {16'b0, r_cfg.gain_y};
            REG_MAX_COUNTS: prdata = {17'b0, r_cfg.max_counts};
            REG_MIN_DT:     prdata = {16'b0, r_cfg.min_dt};
            REG_MAX_DT:     prdata = {16'b0, r_cfg.max_dt};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/rcq_ctrl.sv
// ============================================================================
// Rate-to-count quantizer controller
// Sequences capture, multiply, reciprocal divide, round and result hand-off.
// ============================================================================
module rcq_ctrl
    import rcq_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_rcq_stat i_stat,
    output t_rcq_cmd  o_cmd
);

    localparam int unsigned MW    = MAG_W + FRAC_BITS - SCALE_SH;
    localparam int unsigned ND    = (MW + DIG_W - 1) / DIG_W;
    localparam int unsigned CNT_W = $clog2(ND);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_DIVQ,
        S_DIVR,
        S_SUM,
        S_RND,
        S_FIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.load     = i_in_valid;
            S_MUL1:  o_cmd.mul1     = 1'b1;
            S_MUL2:  o_cmd.mul2     = 1'b1;
            S_DIVQ:  o_cmd.div_est  = 1'b1;
            S_DIVR:  o_cmd.div_fix  = 1'b1;
            S_SUM:   o_cmd.sum      = 1'b1;
            S_RND:   o_cmd.rnd      = 1'b1;
            S_FIN:   o_cmd.finish   = slot_free;
            default: o_cmd          = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= i_stat.bypass ? S_FIN : S_MUL1;
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_cnt   <= CNT_W'(ND - 1);
                    r_state <= S_DIVQ;
                end
                S_DIVQ: begin
                    r_state <= S_DIVR;
                end
                S_DIVR: begin
                    if (r_cnt == '0) begin
                        r_state <= S_SUM;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_DIVQ;
                    end
                end
                S_SUM: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/rcq_dp.sv
// ============================================================================
// Rate-to-count quantizer datapath
// Per-axis multiply, reciprocal division, rounding with residual carry and clamp.
// ============================================================================
module rcq_dp
    import rcq_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = 16,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_rcq_cmd                     i_cmd,
    input  t_rcq_cfg                     i_cfg,
    input  logic                         i_gain_wr,
    input  logic                         i_mode,
    input  logic signed [15:0]           i_rate_x,
    input  logic signed [15:0]           i_rate_y,
    input  logic [15:0]                  i_step_us,
    input  logic                         i_keep_source_x,
    input  logic                         i_keep_source_y,
    input  logic signed [15:0]           i_source_dx,
    input  logic signed [15:0]           i_source_dy,
    output t_rcq_stat                    o_stat,
    output logic signed [COUNT_BITS-1:0] o_step_x,
    output logic signed [COUNT_BITS-1:0] o_step_y,
    output logic                         o_ok,
    output logic                         o_clipped,
    output logic                         o_transparent
);

    localparam int unsigned QW = Q_HEAD + FRAC_BITS;
    localparam int unsigned DW = QW + 2;
    localparam int unsigned CW = FRAC_BITS + 2;
    localparam int unsigned MW = MAG_W + FRAC_BITS - SCALE_SH;
    localparam int unsigned ND = (MW + DIG_W - 1) / DIG_W;
    localparam int unsigned NW = ND * DIG_W;
    localparam int unsigned KW = $bits(DIV_K);
    localparam int unsigned TW = KW + DIG_W;
    localparam int unsigned EW = TW + $bits(RECIP);
    localparam logic [DW-1:0] HALF_D = DW'(1) << (FRAC_BITS - 1);
    localparam logic signed [CW-1:0] HALF_C = CW'(1) << (FRAC_BITS - 1);
    localparam logic [14:0] CAP = (COUNT_BITS >= 16) ? 15'h7FFF
                                                     : 15'((1 << (COUNT_BITS - 1)) - 1);

    function automatic logic [COUNT_BITS-1:0] to_count(input logic [15:0] v);
        logic signed [31:0] w;
        w = 32'(signed'(v));
        return w[COUNT_BITS-1:0];
    endfunction

    logic                  r_mode;
    logic [15:0]           r_step;
    logic [15:0]           r_abs   [2];
    logic                  r_neg   [2];
    logic                  r_keep  [2];
    logic [15:0]           r_src   [2];
    logic [31:0]           r_p1    [2];
    logic [NW-1:0]         r_num   [2];
    logic [KW-1:0]         r_rem   [2];
    logic [TW-1:0]         r_part  [2];
    logic [DIG_W-1:0]      r_qd    [2];
    logic [QW-1:0]         r_q     [2];
    logic signed [DW-1:0]  r_d     [2];
    logic [15:0]           r_rmag  [2];
    logic                  r_dneg  [2];
    logic signed [CW-1:0]  r_res   [2];
    logic signed [CW-1:0]  r_carry [2];

    logic signed [COUNT_BITS-1:0] r_step_x;
    logic signed [COUNT_BITS-1:0] r_step_y;
    logic                         r_ok;
    logic                         r_clipped;
    logic                         r_transparent;

    logic [15:0]                gain    [2];
    logic [15:0]                in_rate [2];
    logic [MAG_W-1:0]           prod    [2];
    logic [MAG_W+FRAC_BITS-1:0] wide    [2];
    logic [TW-1:0]              part    [2];
    logic [EW-1:0]              est     [2];
    logic [TW-1:0]              kprod   [2];
    logic [TW-1:0]              rem_t   [2];
    logic signed [DW-1:0]       qe      [2];
    logic signed [CW-1:0]       c_eff   [2];
    logic [DW-1:0]              absd    [2];
    logic [DW-1:0]              rsum    [2];
    logic signed [CW-1:0]       res_m   [2];
    logic                       clip_a  [2];
    logic [15:0]                mag16   [2];
    logic [15:0]                val16   [2];
    logic [14:0]                lim;
    logic                       win;
    logic                       clip;

    logic signed [CW-1:0]         n_carry [2];
    logic signed [COUNT_BITS-1:0] n_step_x;
    logic signed [COUNT_BITS-1:0] n_step_y;
    logic                         n_ok;
    logic                         n_clipped;
    logic                         n_transparent;

    assign gain[0]    = i_cfg.gain_x;
    assign gain[1]    = i_cfg.gain_y;
    assign in_rate[0] = i_rate_x;
    assign in_rate[1] = i_rate_y;

    assign win = !(r_step < i_cfg.min_dt) && !(r_step > i_cfg.max_dt);
    assign o_stat.bypass = r_mode || !win;

    assign lim = (i_cfg.max_counts > CAP) ? CAP : i_cfg.max_counts;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            prod[a]  = r_p1[a] * r_step;
            wide[a]  = {prod[a], {FRAC_BITS{1'b0}}};
            part[a]  = {r_rem[a], r_num[a][NW-1 -: DIG_W]};
            est[a]   = part[a] * RECIP;
            kprod[a] = r_qd[a] * DIV_K;
            rem_t[a] = r_part[a] - kprod[a];
            qe[a]    = signed'({2'b00, r_q[a]});
            c_eff[a] = r_keep[a] ? '0 : r_carry[a];
            absd[a]  = r_d[a][DW-1] ? DW'(-r_d[a]) : DW'(r_d[a]);
            rsum[a]  = absd[a] + HALF_D;
            res_m[a] = signed'(CW'(rsum[a][FRAC_BITS-1:0])) - HALF_C;
            clip_a[a] = (r_rmag[a] > {1'b0, lim});
            mag16[a]  = clip_a[a] ? {1'b0, lim} : r_rmag[a];
            val16[a]  = r_dneg[a] ? 16'(16'd0 - mag16[a]) : mag16[a];
        end
    end

    assign clip = clip_a[0] || clip_a[1];

    always_comb begin
        n_carry[0]    = r_carry[0];
        n_carry[1]    = r_carry[1];
        n_step_x      = '0;
        n_step_y      = '0;
        n_ok          = 1'b0;
        n_clipped     = 1'b0;
        n_transparent = 1'b0;
        if (r_mode) begin
            n_carry[0]    = '0;
            n_carry[1]    = '0;
            n_step_x      = to_count(r_src[0]);
            n_step_y      = to_count(r_src[1]);
            n_ok          = 1'b1;
            n_transparent = 1'b1;
        end else if (!win) begin
            for (int a = 0; a < 2; a++) begin
                if (r_keep[a]) begin
                    n_carry[a] = '0;
                end
            end
        end else if (clip) begin
            n_carry[0] = '0;
            n_carry[1] = '0;
            n_step_x   = to_count(val16[0]);
            n_step_y   = to_count(val16[1]);
            n_ok       = 1'b1;
            n_clipped  = 1'b1;
        end else begin
            for (int a = 0; a < 2; a++) begin
                n_carry[a] = r_keep[a] ? '0 : r_res[a];
            end
            n_step_x      = to_count(r_keep[0] ? r_src[0] : val16[0]);
            n_step_y      = to_count(r_keep[1] ? r_src[1] : val16[1]);
            n_ok          = 1'b1;
            n_transparent = r_keep[0] && r_keep[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_step    <= i_step_us;
            r_keep[0] <= i_keep_source_x;
            r_keep[1] <= i_keep_source_y;
            r_src[0]  <= i_source_dx;
            r_src[1]  <= i_source_dy;
            for (int a = 0; a < 2; a++) begin
                r_abs[a] <= in_rate[a][15] ? 16'(16'd0 - in_rate[a]) : in_rate[a];
            end
            // Y output is the negated motion, so its sign flips.
            r_neg[0] <= i_rate_x[15];
            r_neg[1] <= ~i_rate_y[15];
        end
        for (int a = 0; a < 2; a++) begin
            if (i_cmd.mul1) begin
                r_p1[a] <= r_abs[a] * gain[a];
            end
            if (i_cmd.mul2) begin
                r_num[a] <= NW'(wide[a][MAG_W+FRAC_BITS-1:SCALE_SH]);
                r_rem[a] <= '0;
            end
            if (i_cmd.div_est) begin
                r_part[a] <= part[a];
                r_qd[a]   <= est[a][RECIP_SH+DIG_W-1:RECIP_SH];
                r_num[a]  <= {r_num[a][NW-DIG_W-1:0], {DIG_W{1'b0}}};
            end
            if (i_cmd.div_fix) begin
                r_rem[a] <= rem_t[a][KW-1:0];
                r_q[a]   <= {r_q[a][QW-DIG_W-1:0], r_qd[a]};
            end
            if (i_cmd.sum) begin
                r_d[a] <= (r_neg[a] ? -qe[a] : qe[a]) + DW'(c_eff[a]);
            end
            if (i_cmd.rnd) begin
                r_rmag[a] <= rsum[a][DW-1:FRAC_BITS];
                r_dneg[a] <= r_d[a][DW-1];
                r_res[a]  <= r_d[a][DW-1] ? -res_m[a] : res_m[a];
            end
        end
        if (i_cmd.finish) begin
            r_step_x      <= n_step_x;
            r_step_y      <= n_step_y;
            r_ok          <= n_ok;
            r_clipped     <= n_clipped;
            r_transparent <= n_transparent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry[0] <= '0;
            r_carry[1] <= '0;
        end else if (i_gain_wr) begin
            r_carry[0] <= '0;
            r_carry[1] <= '0;
        end else if (i_cmd.finish) begin
            r_carry[0] <= n_carry[0];
            r_carry[1] <= n_carry[1];
        end
    end

    assign o_step_x      = r_step_x;
    assign o_step_y      = r_step_y;
    assign o_ok          = r_ok;
    assign o_clipped     = r_clipped;
    assign o_transparent = r_transparent;

endmodule

>>> hw/rtl/rcq_checker.sv
// ============================================================================
// Rate-to-count quantizer checker
// Port-level assertions on result flags, stalls and reset, bound to the top level.
// ============================================================================
module rcq_checker #(
    parameter int unsigned COUNT_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         pready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [COUNT_BITS-1:0] o_step_x,
    input logic signed [COUNT_BITS-1:0] o_step_y,
    input logic                         o_ok,
    input logic                         o_clipped,
    input logic                         o_transparent
);

    // A rejected time step carries no counts and no flags.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_step_x == '0 && o_step_y == '0
                                 && !o_clipped && !o_transparent)
        else $error("rejected item carries nonzero counts or flags");

    // A clipped item is always accepted and never transparent.
    a_clip_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |-> o_ok && !o_transparent)
        else $error("clipped item with inconsistent flags");

    // Transparent results only come from accepted items.
    a_transp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_transparent |-> o_ok)
        else $error("transparent item not marked ok");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_step_x)
                                        && $stable(o_step_y) && $stable(o_ok))
        else $error("stalled result changed");

    // Reset leaves no result pending and the register port ready.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && pready)
        else $error("result pending after reset");

endmodule

bind rate_to_count_quantizer rcq_checker #(.COUNT_BITS(COUNT_BITS)) u_rcq_checker (.*);
